// ----- hdl/text_console_writer_assert.svh -----
// ----------------------------------------------------------------------------
// text_console_writer_assert
// Assertion macros used by the text console sequencer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned CELLS_DEF   = COLUMNS_DEF * ROWS_DEF;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned OFF_W    = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned ATTR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  offset;
    logic              scrolled;
    logic [CELL_W-1:0] value;
  } result_t;

endpackage

// ----- hdl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Teletype text console over a ROWS by COLUMNS cell store.
// ----------------------------------------------------------------------------
// One item is worked at a time, and the cell store's single write port sets
// the pace: a put (character, newline, return, backspace) or an unused opcode
// goes straight to its result, a read in range passes through a read state, a
// clear blanks all ROWS*COLUMNS cells, and a put that scrolls copies the rows
// up and blanks the last row, one cell per cycle. After reset the store is
// cleared in a pass over every cell before the first input beat is taken; the
// attribute register can be written meanwhile. A result sits in an output
// register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tcw_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_column_o,
  output logic [tcw_pkg::OFF_W-1:0]    cursor_offset_o,
  output logic                         scrolled_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_value_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  tcw_pkg::result_t           res;
  logic                       res_ready;
  logic                       out_valid_q, out_valid_d;
  tcw_pkg::result_t           out_q;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register frees up when empty or drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= tcw_pkg::ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_row_o    = out_q.row;
  assign cursor_column_o = out_q.col;
  assign cursor_offset_o = out_q.offset;
  assign scrolled_o      = out_q.scrolled;
  assign cell_value_o    = out_q.value;

endmodule

// ----- hdl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = tcw_pkg::CELL_W,
  parameter int unsigned DEPTH = tcw_pkg::CELLS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tcw_seq.sv -----
// ----------------------------------------------------------------------------
// tcw_seq
// Sequencer of the console: cursor state, single cell writes and reads, and
// the address walker used for clearing and scrolling the cell store.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_seq #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [tcw_pkg::OPCODE_W-1:0]             opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]               char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]                cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]               attr_i,
  output tcw_pkg::result_t                         res_o,
  input  logic                                     res_ready_i,
  output logic                                     ram_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]          ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]               ram_wdata_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]          ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]               ram_rdata_i
);

  localparam int unsigned CELLS     = ROWS * COLUMNS;
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned PW        = $clog2(CELLS + 1);
  localparam int unsigned RW        = $clog2(ROWS);
  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned XW        = (AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W;
  localparam int unsigned LAST_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [PW-1:0]              ptr_q, ptr_d;
  logic [AW-1:0]              dst_q, dst_d;
  logic                       wv_q, wv_d;
  logic [tcw_pkg::CELL_W-1:0] wipe_val_q, wipe_val_d;
  logic                       post_q, post_d;
  logic [RW-1:0]              row_q, row_d;
  logic [CW-1:0]              col_q, col_d;
  logic [AW-1:0]              base_q, base_d;
  logic                       scr_q, scr_d;
  logic [tcw_pkg::CELL_W-1:0] val_q, val_d;

  logic [AW-1:0]              cur;
  logic [tcw_pkg::CELL_W-1:0] blank;
  logic [XW:0]                idx_ext;
  logic                       idx_ok;
  logic                       accept;

  assign cur     = base_q + AW'(col_q);
  assign blank   = {attr_i, tcw_pkg::CH_SPACE};
  assign idx_ext = (XW + 1)'(cell_index_i);
  assign idx_ok  = idx_ext < (XW + 1)'(CELLS);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic adv_row;
    adv_row     = 1'b0;
    state_d     = state_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    wv_d        = wv_q;
    wipe_val_d  = wipe_val_q;
    post_d      = post_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    scr_d       = scr_q;
    val_d       = val_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(ptr_q);
    ram_wdata_o = wipe_val_q;
    ram_raddr_o = AW'(idx_ext);

    unique case (state_q)
      ST_WIPE: begin
        ram_we_o = 1'b1;
        if (ptr_q == PW'(CELLS - 1)) begin
          state_d = post_q ? ST_DONE : ST_IDLE;
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          scr_d   = 1'b0;
          val_d   = '0;
          state_d = ST_DONE;
          unique case (tcw_pkg::op_e'(opcode_i))
            tcw_pkg::OP_PUT: begin
              if (char_code_i == tcw_pkg::CH_NEWLINE) begin
                col_d   = '0;
                adv_row = 1'b1;
              end else if (char_code_i == tcw_pkg::CH_RETURN) begin
                col_d = '0;
              end else if (char_code_i == tcw_pkg::CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d       = col_q - CW'(1);
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cur - AW'(1);
                  ram_wdata_o = blank;
                end
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cur;
                ram_wdata_o = {attr_i, char_code_i};
                if (col_q == CW'(COLUMNS - 1)) begin
                  col_d   = '0;
                  adv_row = 1'b1;
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
              if (adv_row) begin
                if (row_q == RW'(ROWS - 1)) begin
                  // bottom row: copy rows up, then blank the last row
                  scr_d   = 1'b1;
                  ptr_d   = PW'(COLUMNS);
                  wv_d    = 1'b0;
                  state_d = ST_SCROLL;
                end else begin
                  row_d  = row_q + RW'(1);
                  base_d = base_q + AW'(COLUMNS);
                end
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_d      = '0;
              col_d      = '0;
              base_d     = '0;
              ptr_d      = '0;
              wipe_val_d = blank;
              post_d     = 1'b1;
              state_d    = ST_WIPE;
            end
            tcw_pkg::OP_READ: begin
              if (idx_ok) begin
                state_d = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        val_d   = ram_rdata_i;
        state_d = ST_DONE;
      end
      ST_SCROLL: begin
        // read one row ahead, write the beat that came back last cycle
        ram_we_o    = wv_q;
        ram_waddr_o = dst_q;
        ram_wdata_o = ram_rdata_i;
        if (ptr_q != PW'(CELLS)) begin
          ram_raddr_o = AW'(ptr_q);
          ptr_d       = ptr_q + PW'(1);
          wv_d        = 1'b1;
          dst_d       = AW'(ptr_q - PW'(COLUMNS));
        end else begin
          ram_raddr_o = '0;
          wv_d        = 1'b0;
          ptr_d       = PW'(LAST_BASE);
          wipe_val_d  = blank;
          post_d      = 1'b1;
          state_d     = ST_WIPE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o          = '0;
    res_o.valid    = (state_q == ST_DONE);
    res_o.row      = tcw_pkg::ROW_W'(row_q);
    res_o.col      = tcw_pkg::COL_W'(col_q);
    res_o.offset   = tcw_pkg::OFF_W'(cur);
    res_o.scrolled = scr_q;
    res_o.value    = val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_WIPE;
      ptr_q      <= '0;
      dst_q      <= '0;
      wv_q       <= 1'b0;
      wipe_val_q <= tcw_pkg::CELL_RESET;
      post_q     <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      base_q     <= '0;
      scr_q      <= 1'b0;
      val_q      <= '0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      dst_q      <= dst_d;
      wv_q       <= wv_d;
      wipe_val_q <= wipe_val_d;
      post_q     <= post_d;
      row_q      <= row_d;
      col_q      <= col_d;
      base_q     <= base_d;
      scr_q      <= scr_d;
      val_q      <= val_d;
    end
  end

  `TCW_ASSERT_IMP(a_waddr_range, ram_we_o, int'(ram_waddr_o) < CELLS,
                  "cell write outside the store")
  `TCW_ASSERT_IMP(a_cursor_range, 1'b1, (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS),
                  "cursor outside the screen")
  `TCW_ASSERT_IMP(a_row_base, 1'b1, int'(base_q) == int'(row_q) * COLUMNS,
                  "row base out of step with cursor row")
  `TCW_ASSERT_IMP(a_scroll_row, res_o.valid && res_o.scrolled, int'(row_q) == ROWS - 1,
                  "scrolled result not on the last row")
  `TCW_ASSERT_NXT(a_one_item, accept, !in_ready_o,
                  "input taken again right after a beat")

endmodule

// ----- tb/text_console_writer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Keeps its own copy of the screen, cursor and attribute, works out the result
// of every input beat and compares each output beat with the oldest one due.
// ----------------------------------------------------------------------------
module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ATTR_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [IDX_W-1:0]    cell_index_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ROW_W-1:0]    cursor_row_i,
  input  logic [COL_W-1:0]    cursor_column_i,
  input  logic [OFF_W-1:0]    cursor_offset_i,
  input  logic                scrolled_i,
  input  logic [CELL_W-1:0]   cell_value_i,
  output int                  results_o,
  output int                  errors_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  offset;
    logic              scrolled;
    logic [CELL_W-1:0] value;
  } cursor_report_t;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] attr_q;
  cursor_report_t    reports_due[$];
  int                result_cnt;
  int                error_cnt;

  function automatic logic [CELL_W-1:0] blank_word();
    return {attr_q, CH_SPACE};
  endfunction

  // down one row; below the last row the screen moves up instead
  function automatic logic advance_row();
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    cur_row = ROWS - 1;
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = blank_word();
    return 1'b1;
  endfunction

  function automatic cursor_report_t predict_console(logic [OPCODE_W-1:0] op,
                                                     logic [CHAR_W-1:0]   ch,
                                                     logic [IDX_W-1:0]    idx);
    cursor_report_t rep;
    rep = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          cur_col = 0;
          rep.scrolled = advance_row();
        end else if (ch == CH_RETURN) begin
          cur_col = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_mem[cur_row * COLUMNS + cur_col] = blank_word();
          end
        end else begin
          screen_mem[cur_row * COLUMNS + cur_col] = {attr_q, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            rep.scrolled = advance_row();
          end
        end
      end
      OP_CLEAR: begin
        foreach (screen_mem[i]) screen_mem[i] = blank_word();
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (idx < CELLS) rep.value = screen_mem[idx];
      end
      default: ;
    endcase
    rep.row    = ROW_W'(cur_row);
    rep.col    = COL_W'(cur_col);
    rep.offset = OFF_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst_ni) begin
      foreach (screen_mem[i]) screen_mem[i] = CELL_RESET;
      cur_row    = 0;
      cur_col    = 0;
      attr_q     = ATTR_RESET;
      result_cnt = 0;
      error_cnt  = 0;
      reports_due.delete();
    end else begin
      // an output beat always belongs to an input taken at an earlier edge
      if (out_valid_i && out_ready_i) begin
        got = {cursor_row_i, cursor_column_i, cursor_offset_i, scrolled_i, cell_value_i};
        result_cnt++;
        if (reports_due.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("[%0t] result beat with nothing outstanding: row %0d col %0d",
                     $realtime, got.row, got.col);
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            error_cnt++;
            if (error_cnt <= 10) begin
              $display("[%0t] result mismatch on beat %0d", $realtime, result_cnt);
              $display("  expected row %0d col %0d offset %0d scrolled %0b value %04h",
                       want.row, want.col, want.offset, want.scrolled, want.value);
              $display("  actual   row %0d col %0d offset %0d scrolled %0b value %04h",
                       got.row, got.col, got.offset, got.scrolled, got.value);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        reports_due.push_back(predict_console(opcode_i, char_code_i, cell_index_i));
      if (cfg_we_i) attr_q = cfg_wdata_i;
    end
    results_o <= result_cnt;
    errors_o  <= error_cnt;
  end

endmodule

// ----- tb/text_console_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives put, clear, read and spare opcodes into the console under several
// attribute settings, with random gaps and output stalls; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE    = 2'd3;
  localparam logic [IDX_W-1:0]    IDX_MAX     = '1;
  localparam int unsigned         CYCLE_LIMIT = 10_000_000;
  localparam int unsigned         PHASE_ITEMS = 145;
  // longer than a scroll or clear pass
  localparam int unsigned         SETTLE_CYCLES = 2100;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [ATTR_W-1:0]   cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [OPCODE_W-1:0] opcode_i     = '0;
  logic [CHAR_W-1:0]   char_code_i  = '0;
  logic [IDX_W-1:0]    cell_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [ROW_W-1:0]    cursor_row_o;
  logic [COL_W-1:0]    cursor_column_o;
  logic [OFF_W-1:0]    cursor_offset_o;
  logic                scrolled_o;
  logic [CELL_W-1:0]   cell_value_o;

  int   results;
  int   errors;
  int   items_sent = 0;
  int   cycle_cnt  = 0;
  int   rx_stall   = 0;
  logic rx_steady  = 1'b0;
  logic tx_steady  = 1'b0;

  always #5 clk_i = ~clk_i;

  text_console_writer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_row_o   (cursor_row_o),
    .cursor_column_o(cursor_column_o),
    .cursor_offset_o(cursor_offset_o),
    .scrolled_o     (scrolled_o),
    .cell_value_o   (cell_value_o)
  );

  text_console_writer_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_row_i   (cursor_row_o),
    .cursor_column_i(cursor_column_o),
    .cursor_offset_i(cursor_offset_o),
    .scrolled_i     (scrolled_o),
    .cell_value_i   (cell_value_o),
    .results_o      (results),
    .errors_o       (errors)
  );

  // result side: short stalls, a few long ones, and stretches with none
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
      if (!rx_steady && $urandom_range(0, 3) == 0)
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("text_console_writer_tb: errors");
      $finish;
    end
  end

  function automatic int unsigned next_gap();
    int unsigned pick;
    if (tx_steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic hold_off(int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // valid stays up after the beat unless a gap follows
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [IDX_W-1:0] idx);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    hold_off(next_gap());
  endtask

  task automatic wait_idle();
    hold_off(1);
    while (results != items_sent) @(posedge clk_i);
  endtask

  task automatic set_attribute(logic [ATTR_W-1:0] attr);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= attr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    int unsigned      done_cnt;
    int unsigned      kind;
    int unsigned      len;
    logic [IDX_W-1:0] idx;
    done_cnt = 0;
    while (done_cnt < count) begin
      kind      = $urandom_range(0, 99);
      tx_steady = ($urandom_range(0, 4) == 0);
      if (kind < 45) begin
        len = $urandom_range(1, 90);
        repeat (len) send_item(OP_PUT, CHAR_W'($urandom), IDX_W'($urandom));
      end else if (kind < 60) begin
        // long newline runs get the cursor to the bottom and scroll
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
        repeat (len) send_item(OP_PUT, CH_NEWLINE, IDX_W'($urandom));
      end else if (kind < 68) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(OP_PUT, CH_BACKSPACE, IDX_W'($urandom));
      end else if (kind < 88) begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0)
            idx = IDX_W'($urandom_range(CELLS_DEF, IDX_MAX));
          else
            idx = IDX_W'($urandom_range(0, CELLS_DEF - 1));
          send_item(OP_READ, CHAR_W'($urandom), idx);
        end
      end else if (kind < 93) begin
        len = 1;
        send_item(OP_SPARE, CHAR_W'($urandom), IDX_W'($urandom));
      end else if (kind < 96) begin
        len = 1;
        send_item(OP_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
      end else begin
        len = 1;
        send_item(OP_PUT, CH_RETURN, IDX_W'($urandom));
      end
      done_cnt += len;
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset attribute
    send_item(OP_READ, CH_SPACE, '0);
    send_item(OP_PUT, 8'h41, '0);
    send_item(OP_PUT, 8'hFF, '0);
    send_item(OP_PUT, 8'h80, IDX_MAX);
    send_item(OP_PUT, 8'h00, '0);
    send_item(OP_READ, 8'h00, 11'd1);
    send_item(OP_READ, 8'h00, 11'd3);
    send_item(OP_PUT, CH_BACKSPACE, '0);
    send_item(OP_READ, 8'h00, 11'd3);
    send_item(OP_PUT, CH_RETURN, '0);
    send_item(OP_PUT, CH_BACKSPACE, '0);
    send_item(OP_PUT, CH_NEWLINE, '0);
    send_item(OP_PUT, 8'h7F, '0);
    send_item(OP_READ, 8'h00, 11'd80);
    send_item(OP_READ, 8'h00, 11'd1999);
    send_item(OP_READ, 8'hFF, 11'd2000);
    send_item(OP_READ, 8'hFF, IDX_MAX);
    send_item(OP_SPARE, 8'hFF, IDX_MAX);
    send_item(OP_CLEAR, 8'h00, '0);
    send_item(OP_READ, 8'h00, 11'd80);
    send_item(OP_READ, 8'h00, '0);

    set_attribute(8'h00);
    run_random(PHASE_ITEMS);
    set_attribute(8'hFF);
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_W'($urandom));
    run_random(PHASE_ITEMS);
    set_attribute(8'h1E);
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_W'($urandom));
    run_random(PHASE_ITEMS);
    set_attribute(ATTR_RESET);
    run_random(PHASE_ITEMS);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && results == items_sent)
      $display("text_console_writer_tb: clean");
    else
      $display("text_console_writer_tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_seq.sv
hdl/text_console_writer.sv
tb/text_console_writer_checker.sv
tb/text_console_writer_tb.sv
